// ----- rtl/dnt_pkg.sv -----
package dnt_pkg;

	localparam int unsigned CAP_W         = 11;
	localparam int unsigned CAP_RESET     = 1025;
	localparam int unsigned LEFT_W        = 6;
	localparam int unsigned QUEUE_DEPTH_D = 4;

	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_DOT   = 8'h2E;
	localparam logic [7:0] CH_BSL   = 8'h5C;
	localparam logic [7:0] CH_LPAR  = 8'h28;
	localparam logic [7:0] CH_RPAR  = 8'h29;
	localparam logic [7:0] CH_AT    = 8'h40;
	localparam logic [7:0] CH_QUOTE = 8'h22;
	localparam logic [7:0] CH_DOLL  = 8'h24;
	localparam logic [7:0] CH_SEMI  = 8'h3B;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] PRINT_LO = 8'h21;
	localparam logic [7:0] PRINT_HI = 8'h7E;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_RESERVED = 2'd1,
		ST_CAPACITY = 2'd2
	} status_t;

	// kinds of character group the front hands to the back
	typedef enum logic [2:0] {
		GK_DOT     = 3'd0,
		GK_PLAIN   = 3'd1,
		GK_ESC     = 3'd2,
		GK_DEC     = 3'd3,
		GK_NUL     = 3'd4,
		GK_ROOT    = 3'd5,
		GK_DOT_ERR = 3'd6,
		GK_ERR     = 3'd7
	} group_kind_t;

	typedef struct packed {
		group_kind_t        kind;
		logic [7:0]         data;
		logic [CAP_W-1:0]   len;
		status_t            err;
	} group_t;

	typedef struct packed {
		logic [7:0]       ch;
		status_t          status;
		logic             last;
		logic [CAP_W-1:0] len;
	} out_word_t;

	function automatic logic is_special(input logic [7:0] b);
		return (b == CH_DOT) || (b == CH_BSL) || (b == CH_LPAR) || (b == CH_RPAR) ||
			(b == CH_AT) || (b == CH_QUOTE) || (b == CH_DOLL) || (b == CH_SEMI);
	endfunction

	// index of the final word of a group
	function automatic logic [1:0] group_last_idx(input group_kind_t k);
		logic [1:0] r;
		unique case (k)
			GK_ESC, GK_ROOT, GK_DOT_ERR: r = 2'd1;
			GK_DEC:                      r = 2'd3;
			default:                     r = 2'd0;
		endcase
		return r;
	endfunction

endpackage

// ----- rtl/dnt_front.sv -----
module dnt_front (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic [7:0]                wire_byte,
	input  logic                      start_of_name,
	input  logic                      cfg_valid,
	input  logic [dnt_pkg::CAP_W-1:0] cfg_data,
	input  logic                      q_full,
	output logic                      push,
	output dnt_pkg::group_t           push_data
);

	logic [dnt_pkg::LEFT_W-1:0] label_left_q;
	logic [dnt_pkg::CAP_W-1:0]  chars_written_q;
	logic                       discarding_q;
	logic [dnt_pkg::CAP_W-1:0]  capacity_q;

	logic [dnt_pkg::LEFT_W-1:0] ll_e, ll_n;
	logic [dnt_pkg::CAP_W-1:0]  cw_e, cw_n;
	logic                       disc_e, disc_n;
	logic [2:0]                 need;
	logic [dnt_pkg::CAP_W:0]    sum;
	logic                       fits;
	logic                       fits2;
	logic                       grp;
	dnt_pkg::group_t            g;
	logic                       accept;

	assign in_stall = q_full;
	assign accept   = in_valid && !q_full;

	always_comb begin
		ll_e   = start_of_name ? '0 : label_left_q;
		cw_e   = start_of_name ? '0 : chars_written_q;
		disc_e = start_of_name ? 1'b0 : discarding_q;

		// characters this byte would write
		if (ll_e != '0) begin
			if (dnt_pkg::is_special(wire_byte))
				need = 3'd2;
			else if (wire_byte < dnt_pkg::PRINT_LO || wire_byte > dnt_pkg::PRINT_HI)
				need = 3'd4;
			else
				need = 3'd1;
		end else begin
			need = 3'd1;
		end
		sum   = {1'b0, cw_e} + {{(dnt_pkg::CAP_W-2){1'b0}}, need};
		fits  = sum <= {1'b0, capacity_q};
		fits2 = {1'b0, capacity_q} >= (dnt_pkg::CAP_W+1)'(2);

		ll_n   = ll_e;
		cw_n   = cw_e;
		disc_n = disc_e;
		grp    = 1'b0;
		g.kind = dnt_pkg::GK_ERR;
		g.data = wire_byte;
		g.len  = '0;
		g.err  = dnt_pkg::ST_CAPACITY;

		if (disc_e) begin
			grp = 1'b0;
		end else if (ll_e == '0) begin
			grp = 1'b1;
			if (wire_byte == 8'h00) begin
				ll_n = '0;
				cw_n = '0;
				if (!fits) begin
					g.kind = dnt_pkg::GK_ERR;
					disc_n = 1'b1;
				end else if (cw_e == '0) begin
					if (fits2) begin
						g.kind = dnt_pkg::GK_ROOT;
						g.len  = dnt_pkg::CAP_W'(2);
					end else begin
						g.kind = dnt_pkg::GK_DOT_ERR;
						disc_n = 1'b1;
					end
				end else begin
					g.kind = dnt_pkg::GK_NUL;
					g.len  = sum[dnt_pkg::CAP_W-1:0];
				end
			end else if (wire_byte[7:6] != 2'b00) begin
				g.kind = dnt_pkg::GK_ERR;
				g.err  = dnt_pkg::ST_RESERVED;
				ll_n   = '0;
				cw_n   = '0;
				disc_n = 1'b1;
			end else if (cw_e != '0) begin
				if (fits) begin
					g.kind = dnt_pkg::GK_DOT;
					cw_n   = sum[dnt_pkg::CAP_W-1:0];
					ll_n   = wire_byte[dnt_pkg::LEFT_W-1:0];
				end else begin
					g.kind = dnt_pkg::GK_ERR;
					ll_n   = '0;
					cw_n   = '0;
					disc_n = 1'b1;
				end
			end else begin
				grp  = 1'b0;
				ll_n = wire_byte[dnt_pkg::LEFT_W-1:0];
			end
		end else begin
			grp = 1'b1;
			if (fits) begin
				ll_n = ll_e - dnt_pkg::LEFT_W'(1);
				cw_n = sum[dnt_pkg::CAP_W-1:0];
				unique case (need)
					3'd2:    g.kind = dnt_pkg::GK_ESC;
					3'd4:    g.kind = dnt_pkg::GK_DEC;
					default: g.kind = dnt_pkg::GK_PLAIN;
				endcase
			end else begin
				g.kind = dnt_pkg::GK_ERR;
				ll_n   = '0;
				cw_n   = '0;
				disc_n = 1'b1;
			end
		end
	end

	assign push      = accept && grp;
	assign push_data = g;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			label_left_q    <= '0;
			chars_written_q <= '0;
			discarding_q    <= 1'b0;
			capacity_q      <= dnt_pkg::CAP_W'(dnt_pkg::CAP_RESET);
		end else begin
			if (accept) begin
				label_left_q    <= ll_n;
				chars_written_q <= cw_n;
				discarding_q    <= disc_n;
			end
			if (cfg_valid)
				capacity_q <= cfg_data;
		end
	end

endmodule

// ----- rtl/dnt_queue.sv -----
module dnt_queue #(
	parameter int unsigned DEPTH = dnt_pkg::QUEUE_DEPTH_D
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  dnt_pkg::group_t push_data,
	output logic            full,
	input  logic            pop,
	output logic            not_empty,
	output dnt_pkg::group_t pop_data
);

	localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);

	dnt_pkg::group_t slot_q [DEPTH];
	logic [PW-1:0]   wr_ptr_q;
	logic [PW-1:0]   rd_ptr_q;
	logic [CW-1:0]   count_q;
	logic            do_push;
	logic            do_pop;

	assign full      = count_q == CW'(DEPTH);
	assign not_empty = count_q != '0;
	assign pop_data  = slot_q[rd_ptr_q];
	assign do_push   = push && !full;
	assign do_pop    = pop && not_empty;

	function automatic logic [PW-1:0] bump(input logic [PW-1:0] p);
		return (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
	endfunction

	always_ff @(posedge clk) begin
		if (do_push)
			slot_q[wr_ptr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= bump(wr_ptr_q);
			if (do_pop)
				rd_ptr_q <= bump(rd_ptr_q);
			if (do_push && !do_pop)
				count_q <= count_q + CW'(1);
			else if (do_pop && !do_push)
				count_q <= count_q - CW'(1);
		end
	end

endmodule

// ----- rtl/dnt_back.sv -----
module dnt_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              q_not_empty,
	input  dnt_pkg::group_t   q_data,
	output logic              q_pop,
	output logic              out_valid,
	input  logic              out_stall,
	output dnt_pkg::out_word_t out_word
);

	dnt_pkg::group_t    cur_q;
	logic               cur_vld_q;
	logic [1:0]         idx_q;
	logic               out_vld_q;
	dnt_pkg::out_word_t out_q;

	logic               load_ok;
	logic               take;
	logic               done;
	logic [1:0]         hund;
	logic [6:0]         rem;
	logic [14:0]        prod;
	logic [3:0]         tens;
	logic [3:0]         ones;
	dnt_pkg::out_word_t w;

	assign load_ok = !out_vld_q || !out_stall;
	assign take    = load_ok && cur_vld_q;
	assign done    = take && (idx_q == dnt_pkg::group_last_idx(cur_q.kind));
	assign q_pop   = q_not_empty && (!cur_vld_q || done);

	// decimal digits of the byte, tens by reciprocal multiply
	always_comb begin
		if (cur_q.data >= 8'd200)
			hund = 2'd2;
		else if (cur_q.data >= 8'd100)
			hund = 2'd1;
		else
			hund = 2'd0;
		rem  = 7'(cur_q.data - 8'(hund) * 8'd100);
		prod = 15'(rem) * 15'd205;
		tens = prod[14:11];
		ones = 4'(rem - 7'(tens) * 7'd10);
	end

	always_comb begin
		w.ch     = dnt_pkg::CH_NUL;
		w.status = dnt_pkg::ST_OK;
		w.last   = 1'b0;
		w.len    = '0;
		unique case (cur_q.kind)
			dnt_pkg::GK_DOT:   w.ch = dnt_pkg::CH_DOT;
			dnt_pkg::GK_PLAIN: w.ch = cur_q.data;
			dnt_pkg::GK_ESC:   w.ch = (idx_q == 2'd0) ? dnt_pkg::CH_BSL : cur_q.data;
			dnt_pkg::GK_DEC: begin
				unique case (idx_q)
					2'd0: w.ch = dnt_pkg::CH_BSL;
					2'd1: w.ch = dnt_pkg::CH_ZERO + 8'(hund);
					2'd2: w.ch = dnt_pkg::CH_ZERO + 8'(tens);
					2'd3: w.ch = dnt_pkg::CH_ZERO + 8'(ones);
				endcase
			end
			dnt_pkg::GK_NUL: begin
				w.last = 1'b1;
				w.len  = cur_q.len;
			end
			dnt_pkg::GK_ROOT: begin
				if (idx_q == 2'd0) begin
					w.ch = dnt_pkg::CH_DOT;
				end else begin
					w.last = 1'b1;
					w.len  = cur_q.len;
				end
			end
			dnt_pkg::GK_DOT_ERR: begin
				if (idx_q == 2'd0) begin
					w.ch = dnt_pkg::CH_DOT;
				end else begin
					w.status = dnt_pkg::ST_CAPACITY;
					w.last   = 1'b1;
				end
			end
			dnt_pkg::GK_ERR: begin
				w.status = cur_q.err;
				w.last   = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (q_pop)
			cur_q <= q_data;
		if (take)
			out_q <= w;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_vld_q <= 1'b0;
			idx_q     <= '0;
			out_vld_q <= 1'b0;
		end else begin
			if (load_ok)
				out_vld_q <= cur_vld_q;
			if (q_pop) begin
				cur_vld_q <= 1'b1;
				idx_q     <= '0;
			end else if (done) begin
				cur_vld_q <= 1'b0;
				idx_q     <= '0;
			end else if (take) begin
				idx_q <= idx_q + 2'd1;
			end
		end
	end

	assign out_valid = out_vld_q;
	assign out_word  = out_q;

endmodule

// ----- rtl/dns_name_to_text_top.sv -----
// dns wire-form name to presentation text converter
// input channel: one wire byte per word (wire_byte, start_of_name), in_valid/in_stall;
//   a byte is taken whenever in_valid is high and in_stall is low
// output channel: one text character per word (out_char, status, last, total_length),
//   out_valid/out_stall; the receiver holds out_stall high to stall
// config channel: cfg_valid/cfg_ready writes output_capacity, always ready;
//   write it only while no name is in flight
// a byte makes zero to four characters; a non-printable byte makes four
// path: a byte's first character passes the queue slot, the current group
//   register and then the output register
// throughput: the output register moves one character per cycle while
//   out_stall is low; the first length byte of a name and dropped bytes
//   make no characters at the output
// the front keeps taking bytes while the group queue has room, so the input
//   stalls only once the queue fills behind a stalled or busy output
// reset clears label state, character count, error drop mode, the queue count and
//   the output valid flag; capacity returns to 1025
module dns_name_to_text_top #(
	parameter int unsigned QUEUE_DEPTH = dnt_pkg::QUEUE_DEPTH_D
) (
	input  logic                      clk,
	input  logic                      arst_n,
	// input words
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic [7:0]                wire_byte,
	input  logic                      start_of_name,
	// output words
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic [7:0]                out_char,
	output logic [1:0]                status,
	output logic                      last,
	output logic [dnt_pkg::CAP_W-1:0] total_length,
	// capacity register write
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [dnt_pkg::CAP_W-1:0] output_capacity
);

	logic               q_full;
	logic               q_push;
	dnt_pkg::group_t    q_in;
	logic               q_pop;
	logic               q_not_empty;
	dnt_pkg::group_t    q_out;
	dnt_pkg::out_word_t word;

	assign cfg_ready = 1'b1;

	// front: label tracking, escape class, capacity check
	dnt_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.wire_byte     (wire_byte),
		.start_of_name (start_of_name),
		.cfg_valid     (cfg_valid && cfg_ready),
		.cfg_data      (output_capacity),
		.q_full        (q_full),
		.push          (q_push),
		.push_data     (q_in)
	);

	// short queue of character groups between front and back
	dnt_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (q_in),
		.full      (q_full),
		.pop       (q_pop),
		.not_empty (q_not_empty),
		.pop_data  (q_out)
	);

	// back: expands each group into characters, one per cycle while out_stall is low
	dnt_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_not_empty (q_not_empty),
		.q_data      (q_out),
		.q_pop       (q_pop),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.out_word    (word)
	);

	assign out_char     = word.ch;
	assign status       = word.status;
	assign last         = word.last;
	assign total_length = word.len;

	// an error word ends the name and carries no character
	a_err_word: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status != dnt_pkg::ST_OK) |-> last && (out_char == dnt_pkg::CH_NUL))
		else $error("error word malformed");

	// only the final NUL reports a length
	a_len_only_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !last |-> total_length == '0)
		else $error("length on a non-final word");

	// a good NUL always counts at least the NUL and one character
	a_nul_len: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && last && (status == dnt_pkg::ST_OK) |->
			(out_char == dnt_pkg::CH_NUL) && (total_length >= dnt_pkg::CAP_W'(2)))
		else $error("bad terminating word");

	// the queue never takes a group while full
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_full |-> in_stall && !q_push)
		else $error("queue overflow");

endmodule
